>>> hw/rtl/twm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twm_pkg
// Shared types and constants for the trimmed window mean block.
// ----------------------------------------------------------------------------
package twm_pkg;

  localparam logic signed [31:0] SAMPLE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam int                 WLEN_RESET = 16;
  localparam int                 CFG_W      = 7;
  localparam int                 MEAN_W     = 40;
  localparam int                 FRAC_W     = 8;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               store;
    logic               restart;
  } item_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean_q8;
    logic signed [31:0]       highest;
    logic signed [31:0]       lowest;
    logic [CFG_W-1:0]         held_count;
  } result_t;

endpackage

>>> hw/rtl/twm_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twm_ring
// Sample ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module twm_ring #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic signed [31:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic signed [31:0] rdata
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/twm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twm_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twm_divider #(
  parameter int DW = 47,
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int KW = $clog2(DW + 1);

  logic          busy;
  logic [KW-1:0] steps;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] acc;
  logic [VW:0]   trial;
  logic          ge;

  assign trial    = {rem, acc[DW-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= KW'(DW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == KW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      acc <= dividend;
    end else if (busy) begin
      // remainder stays below the divisor, so the low bits hold it
      rem <= ge ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
      acc <= {acc[DW-2:0], ge};
    end
  end

endmodule

>>> hw/rtl/trimmed_window_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_window_mean
// Moving average over a ring of recent samples, dropping one max and one min.
// ----------------------------------------------------------------------------
// One item at a time. An accepted item updates the ring, then the sequencer
// walks the n held samples through the single ring read port, trims once three
// or more are held, and runs a serial divider that yields one quotient bit per
// cycle (33 + log2(WINDOW_MAX) + 8 bits, 47 at the default size) and hands the
// quotient over. item_stall stays high from the accepting edge until the
// result is placed in the output register. A finished result may wait there
// while the next item is already being worked on. Writing window_length
// (nonzero) empties the window; zero is ignored and values above WINDOW_MAX
// saturate.
// ----------------------------------------------------------------------------
module trimmed_window_mean #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  twm_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output twm_pkg::result_t            result,
  input  logic                        cfg_we,
  input  logic [twm_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int LMAX = (WINDOW_MAX > twm_pkg::WLEN_RESET) ? WINDOW_MAX : twm_pkg::WLEN_RESET;
  localparam int CW   = $clog2(LMAX + 1);
  localparam int AW   = $clog2(WINDOW_MAX);
  localparam int SW   = 33 + $clog2(WINDOW_MAX);
  localparam int DW   = SW + twm_pkg::FRAC_W;
  localparam int MW   = twm_pkg::MEAN_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_TRIM = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]           state;
  logic [CW-1:0]        wlen;
  logic [CW-1:0]        write_slot;
  logic [CW-1:0]        fill;
  logic [CW-1:0]        walk_idx;
  logic                 rd_pend;
  logic signed [SW-1:0] sum;
  logic signed [31:0]   hi;
  logic signed [31:0]   lo;
  logic signed [MW-1:0] mean;

  logic                 item_accept;
  logic [CW-1:0]        slot_eff;
  logic [CW-1:0]        fill_eff;
  logic [CW-1:0]        slot_inc;
  logic [CW-1:0]        walk_len;
  logic                 ring_we;
  logic signed [31:0]   rd_data;
  logic                 sum_neg;
  logic [SW-1:0]        sum_mag;
  logic [DW-1:0]        dividend;
  logic [CW-1:0]        divisor;
  logic                 div_start;
  logic                 div_done;
  logic [DW-1:0]        quotient;
  logic [MW-1:0]        q_low;

  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;

  // restart empties the window before the store
  assign slot_eff = item.restart ? '0 : write_slot;
  assign fill_eff = item.restart ? '0 : fill;
  assign slot_inc = slot_eff + 1'b1;
  assign ring_we  = item_accept && item.store && (slot_eff < CW'(WINDOW_MAX));

  assign walk_len = (fill > CW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : fill;

  assign sum_neg   = sum[SW-1];
  assign sum_mag   = sum_neg ? SW'(-sum) : SW'(sum);
  assign dividend  = {sum_mag, {twm_pkg::FRAC_W{1'b0}}};
  assign divisor   = (fill > CW'(2)) ? CW'(fill - CW'(2)) : fill;
  assign div_start = (state == S_PREP) && (fill != '0);
  assign q_low     = quotient[MW-1:0];

  twm_ring #(
    .DEPTH (WINDOW_MAX),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (slot_eff[AW-1:0]),
    .wdata (item.sample),
    .raddr (walk_idx[AW-1:0]),
    .rdata (rd_data)
  );

  twm_divider #(
    .DW (DW),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      wlen         <= CW'(twm_pkg::WLEN_RESET);
      write_slot   <= '0;
      fill         <= '0;
      walk_idx     <= '0;
      rd_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      if (cfg_we && (cfg_wdata != '0)) begin
        if (32'(cfg_wdata) > 32'(WINDOW_MAX)) begin
          wlen <= CW'(WINDOW_MAX);
        end else begin
          wlen <= CW'(cfg_wdata);
        end
        write_slot <= '0;
        fill       <= '0;
      end

      case (state)
        S_IDLE: begin
          if (item_accept) begin
            if (item.store) begin
              fill       <= (fill_eff < wlen) ? CW'(fill_eff + 1'b1) : fill_eff;
              write_slot <= (slot_inc >= wlen) ? '0 : slot_inc;
            end else begin
              fill       <= fill_eff;
              write_slot <= slot_eff;
            end
            walk_idx <= '0;
            rd_pend  <= 1'b0;
            state    <= S_WALK;
          end
        end
        S_WALK: begin
          // ring read data is registered, so it lags the address
          rd_pend <= (walk_idx < walk_len);
          if (walk_idx < walk_len) begin
            walk_idx <= walk_idx + 1'b1;
          end else if (!rd_pend) begin
            state <= S_TRIM;
          end
        end
        S_TRIM: begin
          state <= S_PREP;
        end
        S_PREP: begin
          state <= (fill != '0) ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sum  <= '0;
        hi   <= twm_pkg::SAMPLE_MIN;
        lo   <= twm_pkg::SAMPLE_MAX;
        mean <= '0;
      end
      S_WALK: begin
        if (rd_pend) begin
          sum <= sum + SW'(rd_data);
          if (rd_data > hi) begin
            hi <= rd_data;
          end
          if (rd_data < lo) begin
            lo <= rd_data;
          end
        end
      end
      S_TRIM: begin
        if (fill > CW'(2)) begin
          sum <= sum - SW'(hi) - SW'(lo);
        end
      end
      S_DIV: begin
        if (div_done) begin
          mean <= sum_neg ? MW'(-q_low) : MW'(q_low);
        end
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          result.mean_q8    <= mean;
          result.highest    <= hi;
          result.lowest     <= lo;
          result.held_count <= twm_pkg::CFG_W'(fill);
        end
      end
      default: begin
      end
    endcase
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= wlen)
    else $error("held count above window length");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot < wlen)
    else $error("write slot outside window");

  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    item_accept |=> (state == S_WALK))
    else $error("accepted beat did not start the walk");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside divide phase");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the trimmed window mean block: a queue-fed driver
// and a checking monitor around the block, with an in-bench model of the
// sample ring that predicts count, highest, lowest and the trimmed Q32.8 mean
// for every beat. Runs a directed opening, then random phases under a range
// of window lengths, with random idling on both sides, one long output hold
// and one full drain pause.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_PERIOD      = 12;
  localparam int RING_DEPTH      = 64;
  localparam int N_PHASES        = 16;
  localparam int ITEMS_PER_PHASE = 84;
  localparam int HOLD_CYCLES     = 600;
  localparam int TAIL_CYCLES     = 150;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      item_valid   = 1'b0;
  logic                      item_stall;
  twm_pkg::item_t            item         = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  twm_pkg::result_t          result;
  logic                      cfg_we       = 1'b0;
  logic [twm_pkg::CFG_W-1:0] cfg_wdata    = '0;

  trimmed_window_mean dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // model of the window
  logic signed [31:0] win_ring [RING_DEPTH];
  int                 win_slot = 0;
  int                 win_fill = 0;
  int                 win_len  = twm_pkg::WLEN_RESET;

  twm_pkg::item_t   pending_items [$];
  twm_pkg::result_t expected_results [$];
  twm_pkg::result_t want;

  int errors    = 0;
  int n_items   = 0;
  int n_results = 0;
  int n_cfg     = 0;
  int send_gap  = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit tx_idle   = 1'b1;
  bit rx_idle   = 1'b1;
  bit hold_req  = 1'b0;

  function automatic void set_window_length(int v);
    if (v == 0) return;
    win_len  = (v > RING_DEPTH) ? RING_DEPTH : v;
    win_slot = 0;
    win_fill = 0;
  endfunction

  function automatic twm_pkg::result_t window_mean(twm_pkg::item_t it);
    twm_pkg::result_t r;
    longint  sum, hi, lo, v, mean;
    if (it.restart) begin
      win_slot = 0;
      win_fill = 0;
    end
    if (it.store) begin
      if (win_fill < win_len) win_fill++;
      win_ring[win_slot] = it.sample;
      win_slot++;
      if (win_slot >= win_len) win_slot = 0;
    end
    hi   = twm_pkg::SAMPLE_MIN;
    lo   = twm_pkg::SAMPLE_MAX;
    sum  = 0;
    mean = 0;
    for (int n = 0; n < win_fill; n++) begin
      v = win_ring[n];
      sum += v;
      if (v > hi) hi = v;
      if (v < lo) lo = v;
    end
    // one highest and one lowest are dropped once three or more are held
    if (win_fill > 2) mean = ((sum - hi - lo) * 256) / (win_fill - 2);
    else if (win_fill > 0) mean = (sum * 256) / win_fill;
    r.mean_q8    = mean[twm_pkg::MEAN_W-1:0];
    r.highest    = hi[31:0];
    r.lowest     = lo[31:0];
    r.held_count = win_fill[twm_pkg::CFG_W-1:0];
    return r;
  endfunction

  function automatic twm_pkg::item_t mk(logic signed [31:0] s, logic st, logic rs);
    twm_pkg::item_t it;
    it.sample  = s;
    it.store   = st;
    it.restart = rs;
    return it;
  endfunction

  function automatic twm_pkg::item_t random_item();
    twm_pkg::item_t it;
    int    kind;
    kind = $urandom_range(0, 19);
    if (kind < 8) it.sample = $urandom;
    else if (kind < 11) begin
      case ($urandom_range(0, 4))
        0: it.sample = twm_pkg::SAMPLE_MIN;
        1: it.sample = twm_pkg::SAMPLE_MAX;
        2: it.sample = 0;
        3: it.sample = -1;
        default: it.sample = 1;
      endcase
    end else if (kind < 16) it.sample = $signed($urandom_range(0, 200)) - 100;
    else if (kind < 18) it.sample = twm_pkg::SAMPLE_MAX - $signed($urandom_range(0, 15));
    else it.sample = twm_pkg::SAMPLE_MIN + $signed($urandom_range(0, 15));
    it.store   = ($urandom_range(0, 7) != 0);
    it.restart = ($urandom_range(0, 99) < 2);
    return it;
  endfunction

  task automatic check_field(string name, logic signed [63:0] e, logic signed [63:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  // driver: one beat at a time from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_results.push_back(window_mean(item));
        n_items++;
        if (tx_idle && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 19);
      end
      if (!item_valid || !item_stall) begin
        if (send_gap != 0) begin
          item_valid <= 1'b0;
          send_gap--;
          // chained bursts let gaps outlast the block's busy time
          if (send_gap == 0 && tx_idle && $urandom_range(0, 2) != 0)
            send_gap = $urandom_range(1, 19);
        end else if (pending_items.size() != 0) begin
          item       <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat and drives result_stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %p", $time, result);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("mean_q8", want.mean_q8, result.mean_q8);
          check_field("highest", want.highest, result.highest);
          check_field("lowest", want.lowest, result.lowest);
          check_field("held_count", want.held_count, result.held_count);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        result_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic drain();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_length(int v);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[twm_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    set_window_length(v);
    n_cfg++;
  endtask

  initial begin
    int lengths [10];
    int p, i, len;
    lengths = '{1, 0, 2, 3, 127, 64, 64, 65, 4, 16};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed opening at the reset length
    pending_items.push_back(mk(32'sd0, 1'b0, 1'b0));   // empty window report
    pending_items.push_back(mk(32'sd55, 1'b0, 1'b1));  // restart alone
    pending_items.push_back(mk(twm_pkg::SAMPLE_MAX, 1'b1, 1'b0));
    pending_items.push_back(mk(twm_pkg::SAMPLE_MIN, 1'b1, 1'b0)); // two held, untrimmed
    pending_items.push_back(mk(32'sd0, 1'b1, 1'b0));    // first trimmed mean
    pending_items.push_back(mk(twm_pkg::SAMPLE_MAX, 1'b1, 1'b0));
    pending_items.push_back(mk(twm_pkg::SAMPLE_MAX, 1'b1, 1'b0));
    pending_items.push_back(mk(32'sd123, 1'b0, 1'b0));
    pending_items.push_back(mk(-32'sd1, 1'b1, 1'b1));   // restart then store
    pending_items.push_back(mk(32'sd0, 1'b1, 1'b0));
    pending_items.push_back(mk(32'sd0, 1'b1, 1'b0));
    pending_items.push_back(mk(32'sd10, 1'b1, 1'b0));
    pending_items.push_back(mk(-32'sd10, 1'b1, 1'b0));  // negative mean truncates up
    pending_items.push_back(mk(twm_pkg::SAMPLE_MIN, 1'b1, 1'b1));
    pending_items.push_back(mk(twm_pkg::SAMPLE_MIN, 1'b1, 1'b0));
    pending_items.push_back(mk(twm_pkg::SAMPLE_MIN, 1'b1, 1'b0));
    pending_items.push_back(mk(twm_pkg::SAMPLE_MIN, 1'b1, 1'b0));
    pending_items.push_back(mk(-32'sd7, 1'b0, 1'b1));
    pending_items.push_back(mk(32'sd1, 1'b1, 1'b0));
    pending_items.push_back(mk(32'sd2, 1'b1, 1'b0));
    pending_items.push_back(mk(-32'sd1, 1'b1, 1'b0));

    for (p = 0; p < N_PHASES; p++) begin
      if (p < 10) len = lengths[p];
      else if ($urandom_range(0, 3) == 0) len = $urandom_range(0, 127);
      else len = $urandom_range(1, 20);
      write_length(len);
      @(negedge clk);
      tx_idle = (p < N_PHASES - 2);
      rx_idle = (p < N_PHASES - 2);
      // full window, steady sender, output held off: input backs up
      if (p == 5) begin
        tx_idle  = 1'b0;
        hold_req = 1'b1;
      end
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 8 && i == ITEMS_PER_PHASE / 2) drain();
        pending_items.push_back(random_item());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("covered %0d beats in, %0d results out, %0d length writes", n_items, n_results,
             n_cfg);
    $display("lengths 1 to 64 with zero and saturating writes, one long hold, one drain pause");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 1_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
